@@ hdl/irm_pkg.sv @@
// ----------------------------------------------------------------------------
// irm_pkg
// shared types, codes and constants of the icmp reply matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package irm_pkg;

  localparam int MAX_PACKET = 1024;
  localparam int OFF_W      = $clog2(MAX_PACKET + 1);

  localparam int SUM_DEPTH  = 2;
  localparam int SUM_PTR_W  = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int SUM_CNT_W  = $clog2(SUM_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MIN_IP_HDR  = 20;
  localparam int MSG_HDR_LEN = 8;

  localparam logic [7:0] PROTO_ICMP     = 8'd1;
  localparam logic [7:0] PROTO_TCP      = 8'd6;
  localparam logic [7:0] PROTO_UDP      = 8'd17;
  localparam logic [7:0] MSG_ECHO_REPLY = 8'd0;
  localparam logic [7:0] MSG_UNREACH    = 8'd3;
  localparam logic [7:0] MSG_TIME_EXC   = 8'd11;

  localparam logic [7:0] TTL_TOP_HI  = 8'd255;
  localparam logic [7:0] TTL_TOP_MID = 8'd128;
  localparam logic [7:0] TTL_TOP_LOW = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROBE_MODE  = 3'd0,
    REG_SESSION_ID  = 3'd1,
    REG_PROBE_SEQ   = 3'd2,
    REG_SRC_PORT    = 3'd3,
    REG_TARGET_ADDR = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_ECHO    = 2'd0,
    MODE_VARIANT = 2'd1,
    MODE_UDP     = 2'd2,
    MODE_TCP     = 2'd3
  } probe_mode_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_ECHO     = 2'd1,
    KIND_TIME_EXC = 2'd2,
    KIND_UNREACH  = 2'd3
  } reply_kind_e;

  typedef enum logic [1:0] {
    DEV_UNKNOWN = 2'd0,
    DEV_LOW     = 2'd1,
    DEV_MID     = 2'd2,
    DEV_HI      = 2'd3
  } dev_class_e;

  typedef enum logic [1:0] {
    CHK_NONE = 2'd0,
    CHK_PAIR = 2'd1,
    CHK_PORT = 2'd2
  } chk_e;

  typedef struct packed {
    probe_mode_e probe_mode;
    logic [15:0] session_id;
    logic [15:0] probe_seq;
    logic [15:0] src_port;
    logic [31:0] target_addr;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pkt_in_t;

  typedef struct packed {
    logic        matched;
    reply_kind_e reply_kind;
    logic [31:0] responder_addr;
    logic [7:0]  responder_ttl;
    dev_class_e  device_class;
    logic [6:0]  hop_distance;
    logic        target_hit;
  } res_t;

  typedef struct packed {
    chk_e        chk;
    reply_kind_e kind;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [7:0]  ttl;
    logic [31:0] src;
  } sum_t;

endpackage

@@ hdl/irm_front.sv @@
// ----------------------------------------------------------------------------
// irm_front
// byte parser: captures header fields and classifies the packet on its last
// word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  irm_pkg::pkt_in_t      in_word_i,
  input  irm_pkg::probe_mode_e  probe_mode_i,
  output logic                  sum_valid_o,
  output irm_pkg::sum_t         sum_o
);
  import irm_pkg::*;

  logic [OFF_W-1:0] off_q, off_d, off_len;
  logic [5:0]       hlen_q, hlen_d, ilen_q, ilen_d;
  logic [7:0]       proto_q, proto_d, ttl_q, ttl_d, mtype_q, mtype_d, iproto_q, iproto_d;
  logic [31:0]      src_q, src_d;
  logic [15:0]      eid_q, eid_d, eseq_q, eseq_d, wa_q, wa_d, wb_q, wb_d;
  logic [OFF_W-1:0] h_x, i_x, p_x;
  logic [7:0]       b;
  logic             pos_ok, icmp_mode, base_ok, quote_ok;
  sum_t             sum;

  assign b         = in_word_i.data_byte;
  assign pos_ok    = off_q < OFF_W'(MAX_PACKET);
  assign icmp_mode = (probe_mode_i == MODE_ECHO) || (probe_mode_i == MODE_VARIANT);

  // field capture, later fields see positions from this word's header length
  always_comb begin
    off_len  = pos_ok ? off_q + 1'b1 : off_q;
    hlen_d   = hlen_q;
    ttl_d    = ttl_q;
    proto_d  = proto_q;
    src_d    = src_q;
    mtype_d  = mtype_q;
    eid_d    = eid_q;
    eseq_d   = eseq_q;
    ilen_d   = ilen_q;
    iproto_d = iproto_q;
    wa_d     = wa_q;
    wb_d     = wb_q;
    if (pos_ok && off_q == '0)          hlen_d        = {b[3:0], 2'b00};
    if (pos_ok && off_q == OFF_W'(8))   ttl_d         = b;
    if (pos_ok && off_q == OFF_W'(9))   proto_d       = b;
    if (pos_ok && off_q == OFF_W'(12))  src_d[31:24]  = b;
    if (pos_ok && off_q == OFF_W'(13))  src_d[23:16]  = b;
    if (pos_ok && off_q == OFF_W'(14))  src_d[15:8]   = b;
    if (pos_ok && off_q == OFF_W'(15))  src_d[7:0]    = b;
    h_x = OFF_W'(hlen_d);
    if (pos_ok && off_q == h_x)               mtype_d      = b;
    if (pos_ok && off_q == h_x + OFF_W'(4))   eid_d[15:8]  = b;
    if (pos_ok && off_q == h_x + OFF_W'(5))   eid_d[7:0]   = b;
    if (pos_ok && off_q == h_x + OFF_W'(6))   eseq_d[15:8] = b;
    if (pos_ok && off_q == h_x + OFF_W'(7))   eseq_d[7:0]  = b;
    i_x = h_x + OFF_W'(MSG_HDR_LEN);
    if (pos_ok && off_q == i_x)               ilen_d       = {b[3:0], 2'b00};
    if (pos_ok && off_q == i_x + OFF_W'(9))   iproto_d     = b;
    p_x = i_x + OFF_W'(ilen_d);
    if (icmp_mode) begin
      if (pos_ok && off_q == p_x + OFF_W'(4)) wa_d[15:8] = b;
      if (pos_ok && off_q == p_x + OFF_W'(5)) wa_d[7:0]  = b;
      if (pos_ok && off_q == p_x + OFF_W'(6)) wb_d[15:8] = b;
      if (pos_ok && off_q == p_x + OFF_W'(7)) wb_d[7:0]  = b;
    end else begin
      if (pos_ok && off_q == p_x)             wa_d[15:8] = b;
      if (pos_ok && off_q == p_x + OFF_W'(1)) wa_d[7:0]  = b;
    end
    off_d = off_len;
  end

  // classification on the final word
  always_comb begin
    base_ok  = (off_len >= OFF_W'(MIN_IP_HDR)) && (proto_d == PROTO_ICMP) && (off_len >= i_x);
    quote_ok = (off_len >= i_x + OFF_W'(MIN_IP_HDR)) && (off_len >= p_x + OFF_W'(MSG_HDR_LEN));
    sum      = '0;
    sum.ttl  = ttl_d;
    sum.src  = src_d;
    sum.chk  = CHK_NONE;
    sum.kind = KIND_NONE;
    if (base_ok) begin
      if (mtype_d == MSG_ECHO_REPLY && probe_mode_i == MODE_ECHO) begin
        sum.kind   = KIND_ECHO;
        sum.chk    = CHK_PAIR;
        sum.word_a = eid_d;
        sum.word_b = eseq_d;
      end else if (mtype_d == MSG_TIME_EXC || mtype_d == MSG_UNREACH) begin
        sum.kind   = (mtype_d == MSG_TIME_EXC) ? KIND_TIME_EXC : KIND_UNREACH;
        sum.word_a = wa_d;
        sum.word_b = wb_d;
        if (quote_ok) begin
          if (icmp_mode && iproto_d == PROTO_ICMP) begin
            sum.chk = CHK_PAIR;
          end else if (probe_mode_i == MODE_UDP && iproto_d == PROTO_UDP) begin
            sum.chk = CHK_PORT;
          end else if (probe_mode_i == MODE_TCP && iproto_d == PROTO_TCP) begin
            sum.chk = CHK_PORT;
          end
        end
      end
    end
  end

  assign sum_valid_o = accept_i && in_word_i.last_byte;
  assign sum_o       = sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      hlen_q   <= '0;
      ttl_q    <= '0;
      proto_q  <= '0;
      src_q    <= '0;
      mtype_q  <= '0;
      eid_q    <= '0;
      eseq_q   <= '0;
      ilen_q   <= '0;
      iproto_q <= '0;
      wa_q     <= '0;
      wb_q     <= '0;
    end else if (accept_i) begin
      if (in_word_i.last_byte) begin
        off_q    <= '0;
        hlen_q   <= '0;
        ttl_q    <= '0;
        proto_q  <= '0;
        src_q    <= '0;
        mtype_q  <= '0;
        eid_q    <= '0;
        eseq_q   <= '0;
        ilen_q   <= '0;
        iproto_q <= '0;
        wa_q     <= '0;
        wb_q     <= '0;
      end else begin
        off_q    <= off_d;
        hlen_q   <= hlen_d;
        ttl_q    <= ttl_d;
        proto_q  <= proto_d;
        src_q    <= src_d;
        mtype_q  <= mtype_d;
        eid_q    <= eid_d;
        eseq_q   <= eseq_d;
        ilen_q   <= ilen_d;
        iproto_q <= iproto_d;
        wa_q     <= wa_d;
        wb_q     <= wb_d;
      end
    end
  end

endmodule

@@ hdl/irm_sum_fifo.sv @@
// ----------------------------------------------------------------------------
// irm_sum_fifo
// short queue of packet summaries between the parser and the decision stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irm_sum_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  irm_pkg::sum_t  data_i,
  input  logic           pop_i,
  output irm_pkg::sum_t  data_o,
  output logic           full_o,
  output logic           empty_o
);
  import irm_pkg::*;

  sum_t                 mem_q [SUM_DEPTH];
  logic [SUM_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [SUM_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == SUM_CNT_W'(SUM_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == SUM_PTR_W'(SUM_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == SUM_PTR_W'(SUM_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/irm_back.sv @@
// ----------------------------------------------------------------------------
// irm_back
// decision stage: id and port compare, ttl banding and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           sum_valid_i,
  input  irm_pkg::sum_t  sum_i,
  output logic           sum_pop_o,
  input  irm_pkg::cfg_t  cfg_i,
  input  logic           pop_i,
  output logic           empty_o,
  output irm_pkg::res_t  out_word_o
);
  import irm_pkg::*;

  logic       valid_q;
  res_t       res_q, res_d;
  logic       match;
  logic [7:0] hops;
  dev_class_e cls;

  assign sum_pop_o  = sum_valid_i && (!valid_q || pop_i);
  assign empty_o    = !valid_q;
  assign out_word_o = res_q;

  always_comb begin
    case (sum_i.chk)
      CHK_PAIR: match = (sum_i.word_a == cfg_i.session_id) && (sum_i.word_b == cfg_i.probe_seq);
      CHK_PORT: match = sum_i.word_a == cfg_i.src_port;
      default:  match = 1'b0;
    endcase
    if (sum_i.ttl > TTL_TOP_MID) begin
      cls  = DEV_HI;
      hops = TTL_TOP_HI - sum_i.ttl;
    end else if (sum_i.ttl > TTL_TOP_LOW) begin
      cls  = DEV_MID;
      hops = TTL_TOP_MID - sum_i.ttl;
    end else if (sum_i.ttl != '0) begin
      cls  = DEV_LOW;
      hops = TTL_TOP_LOW - sum_i.ttl;
    end else begin
      cls  = DEV_UNKNOWN;
      hops = '0;
    end
    res_d = '0;
    if (match) begin
      res_d.matched        = 1'b1;
      res_d.reply_kind     = sum_i.kind;
      res_d.responder_addr = sum_i.src;
      res_d.responder_ttl  = sum_i.ttl;
      res_d.device_class   = cls;
      res_d.hop_distance   = hops[6:0];
      res_d.target_hit     = sum_i.src == cfg_i.target_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sum_pop_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

@@ hdl/icmp_reply_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// icmp_reply_matcher_unit
// a packet summary is queued as its last byte is taken and loads the result register once it is empty or popped
// throughput: one packet byte per cycle while the summary queue is not full, set by the byte parser
// a two-entry summary queue and the result register decouple parser and pop
// reset: asynchronous, clears the parser, queues and configuration to zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icmp_reply_matcher_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  irm_pkg::pkt_in_t                  in_word_i,
  output logic                              empty,
  input  logic                              pop,
  output irm_pkg::res_t                     out_word_o,
  input  logic                              cfg_we_i,
  input  logic [irm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [irm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import irm_pkg::*;

  cfg_t cfg_q;
  logic accept, front_valid, fifo_empty, sum_pop;
  sum_t front_sum, fifo_sum;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PROBE_MODE:  cfg_q.probe_mode  <= probe_mode_e'(cfg_data_i[1:0]);
        REG_SESSION_ID:  cfg_q.session_id  <= cfg_data_i[15:0];
        REG_PROBE_SEQ:   cfg_q.probe_seq   <= cfg_data_i[15:0];
        REG_SRC_PORT:    cfg_q.src_port    <= cfg_data_i[15:0];
        REG_TARGET_ADDR: cfg_q.target_addr <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  irm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_word_i    (in_word_i),
    .probe_mode_i (cfg_q.probe_mode),
    .sum_valid_o  (front_valid),
    .sum_o        (front_sum)
  );

  irm_sum_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_sum),
    .pop_i   (sum_pop),
    .data_o  (fifo_sum),
    .full_o  (full),
    .empty_o (fifo_empty)
  );

  irm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (!fifo_empty),
    .sum_i       (fifo_sum),
    .sum_pop_o   (sum_pop),
    .cfg_i       (cfg_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_word_o  (out_word_o)
  );

endmodule

@@ hdl/irm_checker.sv @@
// ----------------------------------------------------------------------------
// irm_checker
// port-level checks on the result side of the reply matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irm_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty,
  input  logic           pop,
  input  irm_pkg::res_t  out_word_o
);
  import irm_pkg::*;

  a_reset_empty : assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result queue not empty after reset");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_word_o))
    else $error("waiting result changed or vanished");

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_word_o.matched |-> out_word_o == '0)
    else $error("rejected result carries nonzero fields");

  a_hit_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_word_o.target_hit |-> out_word_o.matched)
    else $error("target hit without match");

  a_class : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_word_o.matched |->
      out_word_o.reply_kind != KIND_NONE &&
      ((out_word_o.responder_ttl == '0) == (out_word_o.device_class == DEV_UNKNOWN)))
    else $error("matched result with bad kind or ttl class");

endmodule

bind icmp_reply_matcher_unit irm_checker u_irm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_word_o (out_word_o)
);
